/* rtl/icf_pkg.sv */
package icf_pkg;

	localparam int NUM_LINES = 32;
	localparam int ID_WIDTH  = 8;
	localparam int LIDX_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	localparam logic [31:0] ADDR_ICIP = 32'h9005_0000;
	localparam logic [31:0] ADDR_ICMR = 32'h9005_0004;
	localparam logic [31:0] ADDR_ICLR = 32'h9005_0008;
	localparam logic [31:0] ADDR_ICCR = 32'h9005_000c;
	localparam logic [31:0] ADDR_ICFP = 32'h9005_0010;
	localparam logic [31:0] ADDR_ICPR = 32'h9005_0020;
	localparam logic [31:0] FULL_WORD = 32'hffff_ffff;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_SET    = 3'd2,
		OP_TOGGLE = 3'd3,
		OP_BIND   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_ADDR  = 3'd1,
		ST_ALREADY   = 3'd2,
		ST_WRONG_DEV = 3'd3,
		ST_BOUND     = 3'd4,
		ST_BAD_SIZE  = 3'd5
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [31:0]         address;
		logic [31:0]         write_data;
		logic [2:0]          size_bytes;
		logic [4:0]          line_index;
		logic [ID_WIDTH-1:0] device_id;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] irq_lines;
		logic [31:0] fiq_lines;
		status_t     status;
	} result_t;

	// byte-lane mask for a valid access size of 1 to 4
	function automatic logic [31:0] size_mask(input logic [2:0] size);
		logic [31:0] m;
		unique case (size)
			3'd1:    m = FULL_WORD >> 24;
			3'd2:    m = FULL_WORD >> 16;
			3'd3:    m = FULL_WORD >> 8;
			default: m = FULL_WORD;
		endcase
		return m;
	endfunction

endpackage

/* rtl/icf_core.sv */
module icf_core
	import icf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    commit,
	output result_t result
);

	logic [31:0]         pending_q, irq_q, fiq_q, mask_q, level_q, ctrl_q, bound_q;
	logic [ID_WIDTH-1:0] owner_q [NUM_LINES];

	logic [31:0]         pending_d, irq_d, fiq_d, mask_d, level_d, ctrl_d, bound_d;
	logic [31:0]         line_bit, seen;
	logic [ID_WIDTH-1:0] owner;
	logic [LIDX_W-1:0]   lidx;
	logic                line_ok, size_ok, do_flip, do_bind;
	logic [31:0]         rd_val;
	logic                addr_hit;
	logic [31:0]         rd_out;
	status_t             st_out;

	assign lidx     = item.line_index[LIDX_W-1:0];
	assign line_ok  = 32'(item.line_index) < 32'(NUM_LINES);
	assign line_bit = 32'd1 << item.line_index;
	assign owner    = line_ok ? owner_q[lidx] : '0;
	assign size_ok  = (item.size_bytes != 3'd0) && (item.size_bytes <= 3'd4);

	// register read decode
	always_comb begin
		addr_hit = 1'b1;
		unique case (item.address)
			ADDR_ICIP: rd_val = irq_q;
			ADDR_ICMR: rd_val = mask_q;
			ADDR_ICLR: rd_val = level_q;
			ADDR_ICCR: rd_val = ctrl_q;
			ADDR_ICFP: rd_val = fiq_q;
			ADDR_ICPR: rd_val = pending_q;
			default: begin
				rd_val   = '0;
				addr_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		mask_d  = mask_q;
		level_d = level_q;
		ctrl_d  = ctrl_q;
		bound_d = bound_q;
		do_flip = 1'b0;
		do_bind = 1'b0;
		rd_out  = '0;
		st_out  = ST_OK;
		unique case (item.op)
			OP_READ: begin
				if (!size_ok)
					st_out = ST_BAD_SIZE;
				else if (!addr_hit)
					st_out = ST_BAD_ADDR;
				else
					rd_out = rd_val & size_mask(item.size_bytes);
			end
			OP_WRITE: begin
				if (!size_ok)
					st_out = ST_BAD_SIZE;
				else if (!addr_hit)
					st_out = ST_BAD_ADDR;
				else if (item.address == ADDR_ICMR)
					mask_d = item.write_data;
				else if (item.address == ADDR_ICLR)
					level_d = item.write_data;
				else if (item.address == ADDR_ICCR)
					ctrl_d = item.write_data;
			end
			OP_SET: begin
				if (line_ok) begin
					if (item.device_id != owner)
						st_out = ST_WRONG_DEV;
					else if ((pending_q & line_bit) != '0)
						st_out = ST_ALREADY;
					else
						do_flip = 1'b1;
				end
			end
			OP_TOGGLE: do_flip = line_ok;
			OP_BIND: begin
				if (line_ok) begin
					if ((bound_q & line_bit) != '0) begin
						st_out = ST_BOUND;
					end else begin
						bound_d = bound_q | line_bit;
						do_bind = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// IRQ/FIQ only follow a pending change; mask, level and DIM writes wait for it
	always_comb begin
		pending_d = do_flip ? (pending_q ^ line_bit) : pending_q;
		seen      = ctrl_q[0] ? (pending_d & mask_q) : pending_d;
		irq_d     = do_flip ? (seen & ~level_q) : irq_q;
		fiq_d     = do_flip ? (seen & level_q) : fiq_q;
	end

	assign result = '{read_data: rd_out, irq_lines: irq_d, fiq_lines: fiq_d, status: st_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			irq_q     <= '0;
			fiq_q     <= '0;
			mask_q    <= '0;
			level_q   <= '0;
			ctrl_q    <= '0;
			bound_q   <= '0;
			for (int i = 0; i < NUM_LINES; i++)
				owner_q[i] <= '0;
		end else if (commit) begin
			pending_q <= pending_d;
			irq_q     <= irq_d;
			fiq_q     <= fiq_d;
			mask_q    <= mask_d;
			level_q   <= level_d;
			ctrl_q    <= ctrl_d;
			bound_q   <= bound_d;
			if (do_bind)
				owner_q[lidx] <= item.device_id;
		end
	end

endmodule

/* rtl/interrupt_controller_irq_fiq_unit.sv */
// channel | signals                                            | beat taken when
// --------+----------------------------------------------------+--------------------
// in      | in_valid in_ready operation address write_data      | in_valid & in_ready
//         | size_bytes line_index device_id                    |
// out     | out_valid out_ready read_data irq_lines fiq_lines    | out_valid & out_ready
//         | status                                             |
//
// One beat per cycle sustained while out_ready stays high; a beat taken into the input
// register moves into the output-facing result register when the output can advance.
// Register state updates as a beat moves into the result register, so the next
// beat sees it. Reset clears the valid flags, core registers and line owner table.
// A stall holds the full stages; in_ready drops only when both are full.
module interrupt_controller_irq_fiq_unit
	import icf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	input  logic [2:0]  size_bytes,
	input  logic [4:0]  line_index,
	input  logic [7:0]  device_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [31:0] irq_lines,
	output logic [31:0] fiq_lines,
	output logic [2:0]  status
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb, res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op         <= op_t'(operation);
			item_s1.address    <= address;
			item_s1.write_data <= write_data;
			item_s1.size_bytes <= size_bytes;
			item_s1.line_index <= line_index;
			item_s1.device_id  <= ID_WIDTH'(device_id);
		end
		if (advance && valid_s1)
			res_s2 <= res_comb;
	end

	icf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.commit (valid_s1 && advance),
		.result (res_comb)
	);

	assign out_valid = valid_s2;
	assign read_data = res_s2.read_data;
	assign irq_lines = res_s2.irq_lines;
	assign fiq_lines = res_s2.fiq_lines;
	assign status    = res_s2.status;

endmodule

/* rtl/icf_checker.sv */
module icf_checker
	import icf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic [31:0] irq_lines,
	input logic [31:0] fiq_lines,
	input logic [2:0]  status
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
		else $error("stalled result beat changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_BAD_SIZE)
		else $error("status code out of range");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_data == 32'd0)
		else $error("read data on a failed beat");

	a_irq_fiq_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (irq_lines & fiq_lines) == 32'd0)
		else $error("line pending as both IRQ and FIQ");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

endmodule

bind interrupt_controller_irq_fiq_unit icf_checker u_icf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data),
	.irq_lines (irq_lines),
	.fiq_lines (fiq_lines),
	.status    (status)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

import icf_pkg::*;

// Tracks the controller's register file and owner table and holds the
// responses still owed by the block, oldest first.
class intc_tracker;
	logic [31:0]         pend;
	logic [31:0]         irq;
	logic [31:0]         fiq;
	logic [31:0]         mask;
	logic [31:0]         level;
	logic [31:0]         ctrl;
	logic [31:0]         bound;
	logic [ID_WIDTH-1:0] owner [NUM_LINES];
	result_t             due [$];
	int                  errors;

	function new();
		pend = '0;
		irq = '0;
		fiq = '0;
		mask = '0;
		level = '0;
		ctrl = '0;
		bound = '0;
		foreach (owner[i])
			owner[i] = '0;
		errors = 0;
	endfunction

	// flip one pending bit, then rebuild IRQ/FIQ through the DIM gate
	function void flip(input logic [4:0] line);
		logic [31:0] seen;
		pend[line] = ~pend[line];
		seen = ctrl[0] ? (pend & mask) : pend;
		fiq = seen & level;
		irq = seen & ~level;
	endfunction

	function void take_request(input logic [2:0] op, input logic [31:0] addr,
			input logic [31:0] data, input logic [2:0] size,
			input logic [4:0] line, input logic [7:0] id);
		result_t r;
		logic [31:0] v;
		logic [ID_WIDTH-1:0] who;
		r = '0;
		r.status = ST_OK;
		v = '0;
		who = id[ID_WIDTH-1:0];
		if (op == OP_READ || op == OP_WRITE) begin
			// size is judged before the address
			if (size == 3'd0 || size > 3'd4) begin
				r.status = ST_BAD_SIZE;
			end else if (op == OP_WRITE) begin
				case (addr)
					ADDR_ICIP, ADDR_ICFP, ADDR_ICPR: ;
					ADDR_ICMR: mask = data;
					ADDR_ICLR: level = data;
					ADDR_ICCR: ctrl = data;
					default: r.status = ST_BAD_ADDR;
				endcase
			end else begin
				case (addr)
					ADDR_ICIP: v = irq;
					ADDR_ICMR: v = mask;
					ADDR_ICLR: v = level;
					ADDR_ICCR: v = ctrl;
					ADDR_ICFP: v = fiq;
					ADDR_ICPR: v = pend;
					default: r.status = ST_BAD_ADDR;
				endcase
				if (r.status == ST_OK)
					r.read_data = v & (FULL_WORD >> (8 * (4 - size)));
			end
		end else if (op == OP_SET) begin
			if (line < NUM_LINES) begin
				if (who != owner[line])
					r.status = ST_WRONG_DEV;
				else if (pend[line])
					r.status = ST_ALREADY;
				else
					flip(line);
			end
		end else if (op == OP_TOGGLE) begin
			if (line < NUM_LINES)
				flip(line);
		end else if (op == OP_BIND) begin
			if (line < NUM_LINES) begin
				if (bound[line]) begin
					r.status = ST_BOUND;
				end else begin
					bound[line] = 1'b1;
					owner[line] = who;
				end
			end
		end
		r.irq_lines = irq;
		r.fiq_lines = fiq;
		due.push_back(r);
	endfunction

	function void check_result(input logic [31:0] rd, input logic [31:0] irq_seen,
			input logic [31:0] fiq_seen, input logic [2:0] st);
		result_t e;
		if (due.size() == 0) begin
			$display("%0t: unexpected beat: read_data %h irq %h fiq %h status %0d",
				$time, rd, irq_seen, fiq_seen, st);
			errors++;
			return;
		end
		e = due.pop_front();
		if (rd !== e.read_data) begin
			$display("%0t: read_data expected %h got %h", $time, e.read_data, rd);
			errors++;
		end
		if (irq_seen !== e.irq_lines) begin
			$display("%0t: irq_lines expected %h got %h", $time, e.irq_lines, irq_seen);
			errors++;
		end
		if (fiq_seen !== e.fiq_lines) begin
			$display("%0t: fiq_lines expected %h got %h", $time, e.fiq_lines, fiq_seen);
			errors++;
		end
		if (st !== e.status) begin
			$display("%0t: status expected %0d got %0d", $time, e.status, st);
			errors++;
		end
	endfunction
endclass

module tb;

	localparam logic [2:0] OP_TOP      = 3'd7;
	localparam int         RAND_ITEMS  = 1100;
	localparam int         CYCLE_LIMIT = 400000;
	localparam logic [31:0] REG_MAP [6] = '{ADDR_ICIP, ADDR_ICMR, ADDR_ICLR,
		ADDR_ICCR, ADDR_ICFP, ADDR_ICPR};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = '0;
	logic [31:0] address = '0;
	logic [31:0] write_data = '0;
	logic [2:0]  size_bytes = '0;
	logic [4:0]  line_index = '0;
	logic [7:0]  device_id = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic [31:0] irq_lines;
	logic [31:0] fiq_lines;
	logic [2:0]  status;

	intc_tracker tracker = new();
	int          cycle_count = 0;
	logic [15:0] stall_pattern = 16'hffff;
	int          stall_phase = 0;

	interrupt_controller_irq_fiq_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.address    (address),
		.write_data (write_data),
		.size_bytes (size_bytes),
		.line_index (line_index),
		.device_id  (device_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.irq_lines  (irq_lines),
		.fiq_lines  (fiq_lines),
		.status     (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: walk a 16-bit ready pattern, pick a new one at each wrap
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pattern = 16'hffff;
				1: stall_pattern = 16'($urandom) | 16'h0001;
				2: stall_pattern = 16'h0001 << $urandom_range(0, 15);
				default: stall_pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
			endcase
		end
		out_ready <= stall_pattern[stall_phase];
		stall_phase = (stall_phase + 1) % 16;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(read_data, irq_lines, fiq_lines, status);
	end

	task automatic put(input logic [2:0] op, input logic [31:0] addr,
			input logic [31:0] data, input logic [2:0] size,
			input logic [4:0] line, input logic [7:0] id);
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		write_data <= data;
		size_bytes <= size;
		line_index <= line;
		device_id <= id;
		do @(posedge clk); while (!in_ready);
		tracker.take_request(op, addr, data, size, line, id);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic put_random();
		int          pick;
		logic [2:0]  op;
		logic [31:0] addr;
		logic [31:0] data;
		logic [2:0]  size;
		logic [4:0]  line;
		logic [7:0]  id;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			op = OP_READ;
		else if (pick < 40)
			op = OP_WRITE;
		else if (pick < 65)
			op = OP_SET;
		else if (pick < 80)
			op = OP_TOGGLE;
		else if (pick < 95)
			op = OP_BIND;
		else
			op = 3'($urandom_range(int'(OP_BIND) + 1, int'(OP_TOP)));

		pick = $urandom_range(0, 99);
		if (pick < 85)
			addr = REG_MAP[$urandom_range(0, 5)];
		else if (pick < 95)
			addr = ADDR_ICIP + 32'($urandom_range(1, 39));
		else
			addr = $urandom;

		case ($urandom_range(0, 9))
			0: data = '0;
			1: data = FULL_WORD;
			default: data = $urandom;
		endcase

		if ($urandom_range(0, 99) < 88)
			size = 3'($urandom_range(1, 4));
		else
			size = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));

		line = 5'($urandom_range(0, 31));
		// mostly ask as the line's owner so sets get through
		if (op == OP_SET && $urandom_range(0, 9) < 7)
			id = tracker.owner[line];
		else
			id = 8'($urandom);
		put(op, addr, data, size, line, id);
	endtask

	initial begin
		int burst_left;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		put(OP_READ, ADDR_ICIP, '0, 3'd4, 5'd0, 8'd0);
		put(OP_WRITE, ADDR_ICMR, FULL_WORD, 3'd4, 5'd0, 8'd0);
		put(OP_WRITE, ADDR_ICLR, 32'haaaa_aaaa, 3'd1, 5'd0, 8'd0);
		put(OP_WRITE, ADDR_ICIP, FULL_WORD, 3'd4, 5'd0, 8'd0);
		put(OP_WRITE, ADDR_ICFP, FULL_WORD, 3'd2, 5'd0, 8'd0);
		put(OP_WRITE, ADDR_ICPR, FULL_WORD, 3'd3, 5'd0, 8'd0);
		put(OP_WRITE, 32'h0, FULL_WORD, 3'd4, 5'd0, 8'd0);
		put(OP_READ, ADDR_ICMR, '0, 3'd0, 5'd0, 8'd0);
		put(OP_READ, FULL_WORD, '0, 3'd7, 5'd0, 8'd0);
		put(OP_SET, '0, '0, 3'd0, 5'd0, 8'd0);
		put(OP_SET, '0, '0, 3'd0, 5'd0, 8'd0);
		put(OP_SET, '0, '0, 3'd0, 5'd5, 8'hff);
		put(OP_BIND, '0, '0, 3'd0, 5'd31, 8'hff);
		put(OP_BIND, '0, '0, 3'd0, 5'd31, 8'd1);
		put(OP_SET, '0, '0, 3'd0, 5'd31, 8'hff);
		// hide line 31 behind DIM with its mask bit cleared
		put(OP_WRITE, ADDR_ICMR, 32'h7fff_ffff, 3'd4, 5'd0, 8'd0);
		put(OP_WRITE, ADDR_ICCR, 32'h0000_0001, 3'd2, 5'd0, 8'd0);
		put(OP_TOGGLE, '0, '0, 3'd0, 5'd7, 8'd0);
		put(OP_READ, ADDR_ICFP, '0, 3'd3, 5'd0, 8'd0);
		put(OP_READ, ADDR_ICPR, '0, 3'd4, 5'd0, 8'd0);
		put(OP_READ, ADDR_ICLR, '0, 3'd2, 5'd0, 8'd0);
		put(OP_READ, ADDR_ICCR, '0, 3'd1, 5'd0, 8'd0);
		for (int c = int'(OP_BIND) + 1; c <= int'(OP_TOP); c++)
			put(3'(c), FULL_WORD, FULL_WORD, 3'd4, 5'd31, 8'hff);
		put(OP_TOGGLE, '0, '0, 3'd0, 5'd31, 8'd0);

		burst_left = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
			end
			burst_left--;
			put_random();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
		// drain: let any stray beats surface
		repeat (20) @(posedge clk);
		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/icf_pkg.sv
rtl/icf_core.sv
rtl/interrupt_controller_irq_fiq_unit.sv
rtl/icf_checker.sv
tb/tb.sv
